FILE: hw/rtl/rgbcc_pkg.sv
`default_nettype none

package rgbcc_pkg;

  // channel and calibrated value widths
  localparam int CH_W     = 16;
  localparam int CAL_W    = 8;
  localparam int DIV_W    = CH_W + CAL_W;
  localparam int NUM_CH   = 3;

  // matrix coefficients: signed fixed point
  localparam int COEFF_FRAC_BITS = 8;
  localparam int COEFF_W  = COEFF_FRAC_BITS + 4;
  localparam int PROD_W   = COEFF_W + CAL_W + 1;
  localparam int SUM_W    = PROD_W + 2;

  // pipeline depth: setup, scale, one stage per quotient bit, products, sums
  localparam int NORM_STG = CAL_W + 2;
  localparam int CCM_STG  = 2;
  localparam int NSTG     = NORM_STG + CCM_STG;

  // register port
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef logic [CH_W-1:0]           chan_t;
  typedef logic [CAL_W-1:0]          cal_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;

  typedef enum logic [2:0] {
    REG_WHITE_RED   = 3'd0,
    REG_WHITE_GREEN = 3'd1,
    REG_WHITE_BLUE  = 3'd2,
    REG_BLACK_RED   = 3'd3,
    REG_BLACK_GREEN = 3'd4,
    REG_BLACK_BLUE  = 3'd5
  } reg_idx_t;

  // correction matrix in hundredths, row major
  localparam int CCM_HUNDREDTHS [NUM_CH*NUM_CH] = '{
    181,  -10,  -48,
    -46,  632, -242,
    -28, -270,  411
  };

  // round to COEFF_FRAC_BITS fraction bits, halves away from zero
  function automatic coeff_t coeff_fixed(input int idx);
    longint h;
    longint v;
    h = longint'(CCM_HUNDREDTHS[idx]);
    if (h >= 0) begin
      v = (h * (longint'(1) << COEFF_FRAC_BITS) + 50) / 100;
    end else begin
      v = -(((-h) * (longint'(1) << COEFF_FRAC_BITS) + 50) / 100);
    end
    return coeff_t'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgbcc_norm.sv
`default_nettype none

// one channel: (raw - black) * 255 / (white - black), clamped to 0..255
module rgbcc_norm (
  input  wire logic                                 clk,
  input  wire logic [rgbcc_pkg::NORM_STG-1:0]       adv,
  input  wire rgbcc_pkg::chan_t                     raw,
  input  wire rgbcc_pkg::chan_t                     white,
  input  wire rgbcc_pkg::chan_t                     black,
  output rgbcc_pkg::cal_t                           cal
);

  localparam int CW = rgbcc_pkg::CAL_W;
  localparam int DW = rgbcc_pkg::DIV_W;

  // stage 0: differences and range flags
  rgbcc_pkg::chan_t num_r, num_nxt;
  rgbcc_pkg::chan_t rng_r, rng_nxt;
  logic             zero0_r, zero0_nxt;
  logic             sat0_r, sat0_nxt;

  always_comb begin
    num_nxt   = raw - black;
    rng_nxt   = white - black;
    // empty or inverted range, or raw at or below black
    zero0_nxt = (white <= black) || (raw <= black);
    // raw at or above white saturates
    sat0_nxt  = (raw >= white);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_r   <= num_nxt;
      rng_r   <= rng_nxt;
      zero0_r <= zero0_nxt;
      sat0_r  <= sat0_nxt;
    end
  end

  // divider stage registers, index 0 is the scale stage
  logic [DW-1:0]    rem_r  [CW];
  rgbcc_pkg::chan_t d_r    [CW];
  logic [CW-1:0]    q_r    [1:CW];
  logic             zero_r [CW+1];
  logic             sat_r  [CW+1];

  // stage 1: numerator times 255
  logic [DW-1:0] scaled_nxt;
  assign scaled_nxt = {num_r, {CW{1'b0}}} - DW'(num_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rem_r[0]  <= scaled_nxt;
      d_r[0]    <= rng_r;
      zero_r[0] <= zero0_r;
      sat_r[0]  <= sat0_r;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int B = CW - 1 - k;
    logic [DW-1:0] dsh;
    logic          ge;
    logic [CW-1:0] q_nxt;

    assign dsh = DW'(d_r[k]) << B;
    assign ge  = (rem_r[k] >= dsh);

    if (k == 0) begin : g_first
      assign q_nxt = CW'(ge);
    end else begin : g_rest
      assign q_nxt = {q_r[k][CW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv[k+2]) begin
        q_r[k+1]    <= q_nxt;
        zero_r[k+1] <= zero_r[k];
        sat_r[k+1]  <= sat_r[k];
      end
    end

    if (k < CW - 1) begin : g_carry
      logic [DW-1:0] rem_nxt;
      assign rem_nxt = ge ? (rem_r[k] - dsh) : rem_r[k];
      always_ff @(posedge clk) begin
        if (adv[k+2]) begin
          rem_r[k+1] <= rem_nxt;
          d_r[k+1]   <= d_r[k];
        end
      end
    end
  end

  always_comb begin
    if (zero_r[CW]) begin
      cal = '0;
    end else if (sat_r[CW]) begin
      cal = '1;
    end else begin
      cal = q_r[CW];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbcc_ccm.sv
`default_nettype none

// fixed 3x3 correction: products, then row sums with clamp
module rgbcc_ccm (
  input  wire logic                               clk,
  input  wire logic [rgbcc_pkg::CCM_STG-1:0]      adv,
  input  wire rgbcc_pkg::cal_t                    cal [rgbcc_pkg::NUM_CH],
  output rgbcc_pkg::cal_t                         res [rgbcc_pkg::NUM_CH]
);

  localparam int NC = rgbcc_pkg::NUM_CH;
  localparam int PW = rgbcc_pkg::PROD_W;
  localparam int SW = rgbcc_pkg::SUM_W;
  localparam int FB = rgbcc_pkg::COEFF_FRAC_BITS;
  localparam int CW = rgbcc_pkg::CAL_W;

  logic signed [PW-1:0] prod_r [NC*NC];
  rgbcc_pkg::cal_t      res_r  [NC];

  for (genvar r = 0; r < NC; r++) begin : g_row
    for (genvar c = 0; c < NC; c++) begin : g_col
      localparam rgbcc_pkg::coeff_t COEF = rgbcc_pkg::coeff_fixed(r * NC + c);
      logic signed [PW-1:0] prod_nxt;
      assign prod_nxt = PW'($signed({1'b0, cal[c]})) * PW'(COEF);
      always_ff @(posedge clk) begin
        if (adv[0]) begin
          prod_r[r*NC+c] <= prod_nxt;
        end
      end
    end

    logic signed [SW-1:0] sum;
    rgbcc_pkg::cal_t      res_nxt;

    assign sum = SW'(prod_r[r*NC]) + SW'(prod_r[r*NC+1]) + SW'(prod_r[r*NC+2]);

    always_comb begin
      if (sum[SW-1]) begin
        res_nxt = '0;
      end else if (|sum[SW-2:FB+CW]) begin
        res_nxt = '1;
      end else begin
        res_nxt = sum[FB+CW-1:FB];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[1]) begin
        res_r[r] <= res_nxt;
      end
    end

    assign res[r] = res_r[r];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_calibrate_and_color_correct_core.sv
`default_nettype none

// rgb sensor calibration and color correction
//
// in_*  : one raw sample per word, three 16-bit counts
// out_* : one corrected pixel per word, three 8-bit values
// cfg_* : register port, white references at 0x00/0x04/0x08 (red, green,
//         blue), black references at 0x0c/0x10/0x14, 16 bits each, read back
//
// each channel is scaled to 0..255 between its black and white reference by
// a restoring divider, one quotient bit per stage, then a constant 3x3 matrix
// is applied with one product stage and one sum/clamp stage
// twelve register stages; while the receiver keeps out_tready high, one word
// per clock is sustained
// reset empties the pipeline and clears all references to zero
// when the receiver stalls, words stay in place stage by stage; in_tready
// stays high while any empty stage remains, so bubbles are squeezed out
// references are to be written only while the block is idle (left to the user, unchecked)

module rgb_calibrate_and_color_correct_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [47:0]                       in_tdata,   // raw_red, raw_green, raw_blue

  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [23:0]                       out_tdata,  // red_out, green_out, blue_out

  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rgbcc_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [rgbcc_pkg::DATA_W-1:0]      cfg_pwdata,
  output      logic [rgbcc_pkg::DATA_W-1:0]      cfg_prdata,
  output      logic                              cfg_pready
);

  localparam int NS = rgbcc_pkg::NSTG;
  localparam int NN = rgbcc_pkg::NORM_STG;
  localparam int NC = rgbcc_pkg::NUM_CH;
  localparam int CH = rgbcc_pkg::CH_W;
  localparam int CW = rgbcc_pkg::CAL_W;

  // ------------------------------------------------------------------
  // reference registers
  // ------------------------------------------------------------------
  rgbcc_pkg::chan_t   white_r [NC];
  rgbcc_pkg::chan_t   black_r [NC];
  rgbcc_pkg::reg_idx_t reg_idx;
  logic               reg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = rgbcc_pkg::reg_idx_t'(cfg_paddr[rgbcc_pkg::ADDR_W-1:2]);
  assign reg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        white_r[i] <= '0;
        black_r[i] <= '0;
      end
    end else if (reg_wr) begin
      case (reg_idx)
        rgbcc_pkg::REG_WHITE_RED:   white_r[0] <= cfg_pwdata[CH-1:0];
        rgbcc_pkg::REG_WHITE_GREEN: white_r[1] <= cfg_pwdata[CH-1:0];
        rgbcc_pkg::REG_WHITE_BLUE:  white_r[2] <= cfg_pwdata[CH-1:0];
        rgbcc_pkg::REG_BLACK_RED:   black_r[0] <= cfg_pwdata[CH-1:0];
        rgbcc_pkg::REG_BLACK_GREEN: black_r[1] <= cfg_pwdata[CH-1:0];
        rgbcc_pkg::REG_BLACK_BLUE:  black_r[2] <= cfg_pwdata[CH-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rgbcc_pkg::REG_WHITE_RED:   cfg_prdata = rgbcc_pkg::DATA_W'(white_r[0]);
      rgbcc_pkg::REG_WHITE_GREEN: cfg_prdata = rgbcc_pkg::DATA_W'(white_r[1]);
      rgbcc_pkg::REG_WHITE_BLUE:  cfg_prdata = rgbcc_pkg::DATA_W'(white_r[2]);
      rgbcc_pkg::REG_BLACK_RED:   cfg_prdata = rgbcc_pkg::DATA_W'(black_r[0]);
      rgbcc_pkg::REG_BLACK_GREEN: cfg_prdata = rgbcc_pkg::DATA_W'(black_r[1]);
      rgbcc_pkg::REG_BLACK_BLUE:  cfg_prdata = rgbcc_pkg::DATA_W'(black_r[2]);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or the next one loads
  // ------------------------------------------------------------------
  logic [NS-1:0] vld_r, vld_nxt, vld_in, adv;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign adv     = rdy[NS-1:0];
  assign vld_in  = {vld_r[NS-2:0], in_tvalid};
  assign vld_nxt = (adv & vld_in) | (~adv & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NS-1];

  // ------------------------------------------------------------------
  // datapath
  // ------------------------------------------------------------------
  rgbcc_pkg::cal_t cal [NC];
  rgbcc_pkg::cal_t res [NC];

  for (genvar c = 0; c < NC; c++) begin : g_ch
    rgbcc_norm u_norm (
      .clk   (clk),
      .adv   (adv[NN-1:0]),
      .raw   (in_tdata[c*CH +: CH]),
      .white (white_r[c]),
      .black (black_r[c]),
      .cal   (cal[c])
    );
    assign out_tdata[c*CW +: CW] = res[c];
  end

  rgbcc_ccm u_ccm (
    .clk (clk),
    .adv (adv[NS-1:NN]),
    .cal (cal),
    .res (res)
  );

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------

  // with an empty output stage every stage can move, so input is open
  a_ready_when_drained: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready
  ) else $error("input blocked while output stage empty");

  // a word held in the last divider stage survives a blocked successor
  a_hold_in_stall: assert property (
    @(posedge clk) disable iff (!rst_n)
    (vld_r[NN-1] && !rdy[NN]) |=> vld_r[NN-1]
  ) else $error("word dropped from divider output while stalled");

  // output only becomes valid from a word in the sum stage's feeder
  a_out_from_pipe: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[NS-2])
  ) else $error("output word appeared without a source");

endmodule

`default_nettype wire

FILE: tb/rgb_calibrate_and_color_correct_core_tb.sv
`timescale 1ns / 100ps

module rgb_calibrate_and_color_correct_core_tb;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 5;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_IDLE     = 5;
  // pipeline depth plus margin, waited out once at the very end
  localparam int DRAIN_CYCLES = rgbcc_pkg::NSTG + 8;
  // run time limit in ns, far above the slowest legal run
  localparam int RUN_LIMIT_NS = 10_000_000;

  // register slots the address decoder has no register for
  localparam int SPARE_IDX_LO = 6;
  localparam int SPARE_IDX_HI = 7;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;

  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [47:0]                    in_tdata    = '0;  // raw_red, raw_green, raw_blue

  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [23:0]                    out_tdata;         // red_out, green_out, blue_out

  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [rgbcc_pkg::ADDR_W-1:0]   cfg_paddr   = '0;
  logic [rgbcc_pkg::DATA_W-1:0]   cfg_pwdata  = '0;
  logic [rgbcc_pkg::DATA_W-1:0]   cfg_prdata;
  logic                           cfg_pready;

  // shadow copy of the black and white references, index 0 red .. 2 blue
  logic [15:0] white_shadow [3];
  logic [15:0] black_shadow [3];

  // raw samples still to send, and corrected pixels still to arrive
  logic [47:0] raw_backlog [$];
  logic [23:0] pixel_due [$];

  logic [47:0] raw_now = '0;
  logic [23:0] want_pix;
  bit          in_busy, in_taken, out_taken;
  int          in_gap, in_calm, out_wait, out_calm;
  int          fault_count;
  string       chan_tag [3] = '{"red", "green", "blue"};

  rgb_calibrate_and_color_correct_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // color pipeline prediction
  // ---------------------------------------------------------------------------

  // correction matrix in hundredths, row major
  function automatic int mix_hundredths(int k);
    case (k)
      0:       return 181;
      1:       return -10;
      2:       return -48;
      3:       return -46;
      4:       return 632;
      5:       return -242;
      6:       return -28;
      7:       return -270;
      default: return 411;
    endcase
  endfunction

  // coefficient in fixed point, magnitude rounded half up, sign put back after
  function automatic longint mix_weight(int k);
    longint h;
    longint mag;
    h   = mix_hundredths(k);
    mag = ((h < 0 ? -h : h) * (longint'(1) << rgbcc_pkg::COEFF_FRAC_BITS) + 50) / 100;
    return (h < 0) ? -mag : mag;
  endfunction

  function automatic logic [23:0] correct_pixel(logic [47:0] raw);
    longint lvl [3];
    longint span, num, acc, q;
    logic [23:0] pix;
    pix = '0;
    // black/white stretch, anything outside the reference window pins
    for (int c = 0; c < 3; c++) begin
      span = longint'(white_shadow[c]) - longint'(black_shadow[c]);
      num  = longint'(raw[16*c +: 16]) - longint'(black_shadow[c]);
      if (span <= 0 || num <= 0) begin
        lvl[c] = 0;
      end else begin
        q      = (num * 255) / span;
        lvl[c] = (q > 255) ? 255 : q;
      end
    end
    // matrix rows, negative sums floor at zero, positive ones truncate
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += mix_weight(3*r + k) * lvl[k];
      if (acc <= 0) begin
        q = 0;
      end else begin
        q = acc >>> rgbcc_pkg::COEFF_FRAC_BITS;
        if (q > 255) q = 255;
      end
      pix[8*r +: 8] = q[7:0];
    end
    return pix;
  endfunction

  task automatic flag_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // sender: fed from raw_backlog, a drawn idle gap after every accepted word,
  // now and then a stretch of back-to-back words
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy  = 1'b0;
      if (in_calm > 0) begin
        in_calm--;
        in_gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        in_calm = $urandom_range(20, 60);
        in_gap  = 0;
      end else begin
        in_gap = $urandom_range(0, MAX_IDLE);
      end
    end
    if (rst_n && !in_busy && raw_backlog.size() != 0) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        raw_now = raw_backlog.pop_front();
        in_busy = 1'b1;
      end
    end
    // zero gap keeps valid high across words with a single update
    in_tvalid <= in_busy;
    in_tdata  <= raw_now;
  end

  // ---------------------------------------------------------------------------
  // receiver: drawn stall after every accepted word, with calm stretches too
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if (out_calm > 0) begin
        out_calm--;
        out_wait = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        out_calm = $urandom_range(20, 60);
        out_wait = 0;
      end else begin
        out_wait = $urandom_range(0, MAX_IDLE);
      end
    end
    if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input handshake, compare on output handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready === 1'b1) begin
      pixel_due.push_back(correct_pixel(in_tdata));
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      out_taken = 1'b1;
      if (pixel_due.size() == 0) begin
        flag_fault($sformatf("word %h with nothing expected", out_tdata));
      end else begin
        want_pix = pixel_due.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (out_tdata[8*f +: 8] !== want_pix[8*f +: 8])
            flag_fault($sformatf("%s_out expected %0d got %0d (%h)", chan_tag[f],
                                 want_pix[8*f +: 8], out_tdata[8*f +: 8], out_tdata));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  // upper half of the write data is junk the block must drop
  task automatic reg_write(int idx, logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom), val};
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= rgbcc_pkg::ADDR_W'(4 * idx);
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // spare slots leave the shadow untouched
    if (idx >= rgbcc_pkg::REG_BLACK_RED && idx <= rgbcc_pkg::REG_BLACK_BLUE)
      black_shadow[idx - rgbcc_pkg::REG_BLACK_RED] = val;
    else if (idx >= rgbcc_pkg::REG_WHITE_RED && idx <= rgbcc_pkg::REG_WHITE_BLUE)
      white_shadow[idx - rgbcc_pkg::REG_WHITE_RED] = val;
  endtask

  task automatic reg_verify(int idx);
    logic [15:0] held;
    held = (idx >= rgbcc_pkg::REG_BLACK_RED) ? black_shadow[idx - rgbcc_pkg::REG_BLACK_RED]
                                             : white_shadow[idx - rgbcc_pkg::REG_WHITE_RED];
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= rgbcc_pkg::ADDR_W'(4 * idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[15:0] !== held)
      flag_fault($sformatf("register %0d read expected %h got %h", idx, held,
                           cfg_prdata[15:0]));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_refs();
    for (int i = rgbcc_pkg::REG_WHITE_RED; i <= rgbcc_pkg::REG_BLACK_BLUE; i++)
      reg_verify(i);
  endtask

  task automatic set_channel(int c, logic [15:0] white, logic [15:0] black);
    reg_write(rgbcc_pkg::REG_WHITE_RED + c, white);
    reg_write(rgbcc_pkg::REG_BLACK_RED + c, black);
  endtask

  // random reference pair per channel, extremes and broken ranges included
  task automatic pick_channel(int c);
    int lo, hi;
    case ($urandom_range(0, 9))
      0:       begin lo = 0;       hi = 16'hFFFF; end
      1:       begin lo = 0;       hi = 1; end
      2:       begin lo = 16'hFFFE; hi = 16'hFFFF; end
      3, 4:    begin
        lo = $urandom_range(0, 16'hFFF0);
        hi = lo + $urandom_range(1, 15);
      end
      5:       begin
        hi = $urandom_range(0, 16'hFFFE);
        lo = $urandom_range(hi + 1, 16'hFFFF);
      end
      6:       begin lo = $urandom_range(0, 16'hFFFF); hi = lo; end
      default: begin
        lo = $urandom_range(0, 16'hFFFE);
        hi = $urandom_range(lo + 1, 16'hFFFF);
      end
    endcase
    set_channel(c, hi[15:0], lo[15:0]);
  endtask

  // mostly around the reference window so the stretch and matrix see real
  // values, the rest anywhere in the 16-bit range
  function automatic logic [15:0] raw_draw(int c);
    int lo, hi;
    lo = black_shadow[c];
    hi = white_shadow[c];
    if (hi <= lo || $urandom_range(0, 4) == 0) return 16'($urandom);
    lo = (lo < 20) ? 0 : lo - 20;
    hi = (hi > 16'hFFFF - 20) ? 16'hFFFF : hi + 20;
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic queue_raw(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    raw_backlog.push_back({b, g, r});
  endtask

  // stimulus holds off until every word sent has come back
  task automatic drain();
    do @(posedge clk);
    while (raw_backlog.size() != 0 || in_busy || pixel_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < 3; c++) begin
      white_shadow[c] = '0;
      black_shadow[c] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // references all zero out of reset: empty range on every channel
    queue_raw(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_raw(16'h1234, 16'h0000, 16'h8000);
    drain();
    check_refs();

    // full-scale references, matrix extremes and bit patterns
    for (int c = 0; c < 3; c++) set_channel(c, 16'hFFFF, 16'h0000);
    check_refs();
    queue_raw(16'h0000, 16'h0000, 16'h0000);
    queue_raw(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_raw(16'hFFFF, 16'h0000, 16'h0000);
    queue_raw(16'h0000, 16'hFFFF, 16'h0000);
    queue_raw(16'h0000, 16'h0000, 16'hFFFF);
    queue_raw(16'h8000, 16'h8000, 16'h8000);
    queue_raw(16'hAAAA, 16'h5555, 16'hAAAA);
    queue_raw(16'h5555, 16'hAAAA, 16'h5555);
    queue_raw(16'h0101, 16'h4000, 16'h0080);
    drain();

    // red normal window, green empty window, blue inverted window;
    // spare slots written on the way and must change nothing
    set_channel(0, 16'd5000, 16'd1000);
    set_channel(1, 16'd3000, 16'd3000);
    set_channel(2, 16'd20000, 16'd60000);
    reg_write(SPARE_IDX_LO, 16'hBEEF);
    reg_write(SPARE_IDX_HI, 16'h1234);
    check_refs();
    queue_raw(16'd999, 16'd3000, 16'd65535);   // below black
    queue_raw(16'd1000, 16'd2999, 16'd0);      // at black
    queue_raw(16'd1001, 16'd3001, 16'd20000);
    queue_raw(16'd5000, 16'd65535, 16'd60000); // at white
    queue_raw(16'd5001, 16'd0, 16'd60001);     // above white
    queue_raw(16'd65535, 16'd3000, 16'd40000);
    queue_raw(16'd3000, 16'd100, 16'd19999);
    drain();

    // random phases, new references each time
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int c = 0; c < 3; c++) pick_channel(c);
      if ($urandom_range(0, 1) == 1)
        reg_write($urandom_range(0, 1) ? SPARE_IDX_HI : SPARE_IDX_LO, 16'($urandom));
      check_refs();
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_raw(raw_draw(0), raw_draw(1), raw_draw(2));
      drain();
    end

    // let any stray word surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
